// ===== hdl/aks_pkg.sv =====
`default_nettype none

package aks_pkg;

	// widths of the beat fields
	localparam int ADC_BITS         = 10;
	localparam int LEVEL_BITS       = 8;
	localparam int KEY_BITS         = 4;
	localparam int S_TDATA_BITS     = ((ADC_BITS + 2 + 7) / 8) * 8;
	localparam int M_TDATA_BITS     = ((KEY_BITS + 7) / 8) * 8;
	localparam int CFG_INDEX_BITS   = 4;
	localparam int NUM_LIMITS       = 7;
	localparam int SLOT_BITS        = 3;

	// press timing
	localparam int LONG_PRESS_TICKS = 120;

	// result queue
	localparam int OUTQ_DEPTH       = 4;
	localparam int OUTQ_PTR_BITS    = $clog2(OUTQ_DEPTH);
	localparam int OUTQ_CNT_BITS    = $clog2(OUTQ_DEPTH + 1);

	typedef logic [LEVEL_BITS-1:0] level_t;
	typedef logic [KEY_BITS-1:0]   key_t;

	// register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_PRESS_THRESHOLD = 4'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL0_LIMIT    = 4'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL1_LIMIT    = 4'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL2_LIMIT    = 4'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL3_LIMIT    = 4'd4;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL4_LIMIT    = 4'd5;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL5_LIMIT    = 4'd6;
	localparam logic [CFG_INDEX_BITS-1:0] REG_LEVEL6_LIMIT    = 4'd7;

	// register reset values
	localparam level_t RST_PRESS_THRESHOLD = 8'd240;
	localparam level_t RST_LEVEL0_LIMIT    = 8'd20;
	localparam level_t RST_LEVEL1_LIMIT    = 8'd50;
	localparam level_t RST_LEVEL2_LIMIT    = 8'd80;
	localparam level_t RST_LEVEL3_LIMIT    = 8'd110;
	localparam level_t RST_LEVEL4_LIMIT    = 8'd140;
	localparam level_t RST_LEVEL5_LIMIT    = 8'd170;
	localparam level_t RST_LEVEL6_LIMIT    = 8'd200;

	// key codes
	localparam key_t KC_MUTE     = 4'd0;
	localparam key_t KC_POWER    = 4'd1;
	localparam key_t KC_NAV      = 4'd2;
	localparam key_t KC_HOME     = 4'd3;
	localparam key_t KC_MODE     = 4'd4;
	localparam key_t KC_CAMERA   = 4'd5;
	localparam key_t KC_NEXT     = 4'd6;
	localparam key_t KC_PREV     = 4'd7;
	localparam key_t KC_FASTFWD  = 4'd8;
	localparam key_t KC_FASTBACK = 4'd9;
	localparam key_t KC_LONGEND  = 4'd10;

	// key slots
	localparam logic [SLOT_BITS-1:0] SLOT_0    = 3'd0;
	localparam logic [SLOT_BITS-1:0] SLOT_1    = 3'd1;
	localparam logic [SLOT_BITS-1:0] SLOT_2    = 3'd2;
	localparam logic [SLOT_BITS-1:0] SLOT_3    = 3'd3;
	localparam logic [SLOT_BITS-1:0] SLOT_4    = 3'd4;
	localparam logic [SLOT_BITS-1:0] SLOT_5    = 3'd5;
	localparam logic [SLOT_BITS-1:0] SLOT_6    = 3'd6;
	localparam logic [SLOT_BITS-1:0] SLOT_NONE = 3'd7;

	typedef enum logic [4:0] {
		ST_IDLE    = 5'b00001,
		ST_PRESS1  = 5'b00010,
		ST_PRESS2  = 5'b00100,
		ST_LONG    = 5'b01000,
		ST_RELEASE = 5'b10000
	} scan_state_t;

	typedef struct packed {
		level_t                       press_threshold;
		logic [NUM_LIMITS-1:0][LEVEL_BITS-1:0] level_limit;
	} cfg_t;

	// optional key code
	typedef struct packed {
		logic vld;
		key_t code;
	} key_opt_t;

	// results of one tick, in delivery order
	typedef struct packed {
		logic [1:0] num;
		key_t       code_a;
		key_t       code_b;
	} key_push_t;

	// first slot whose limit the level does not exceed
	function automatic logic [SLOT_BITS-1:0] slot_of(
		input level_t                                lvl,
		input logic [NUM_LIMITS-1:0][LEVEL_BITS-1:0] lim
	);
		logic [SLOT_BITS-1:0] s;
		s = SLOT_NONE;
		for (int i = NUM_LIMITS - 1; i >= 0; i--) begin
			if (lvl <= lim[i]) begin
				s = SLOT_BITS'(i);
			end
		end
		return s;
	endfunction

	function automatic key_opt_t short_code(input logic [SLOT_BITS-1:0] s, input logic pw);
		key_opt_t k;
		k.vld = 1'b1;
		case (s)
			SLOT_0:  k.code = pw ? KC_POWER : KC_MUTE;
			SLOT_1:  k.code = KC_NAV;
			SLOT_2:  k.code = KC_HOME;
			SLOT_3:  k.code = KC_MODE;
			SLOT_4:  k.code = KC_CAMERA;
			SLOT_5:  k.code = KC_NEXT;
			SLOT_6:  k.code = KC_PREV;
			default: begin
				k.vld  = 1'b0;
				k.code = KC_MUTE;
			end
		endcase
		return k;
	endfunction

	function automatic key_opt_t long_code(input logic [SLOT_BITS-1:0] s);
		key_opt_t k;
		k.vld = 1'b1;
		case (s)
			SLOT_0:  k.code = KC_POWER;
			SLOT_5:  k.code = KC_FASTFWD;
			SLOT_6:  k.code = KC_FASTBACK;
			default: begin
				k.vld  = 1'b0;
				k.code = KC_MUTE;
			end
		endcase
		return k;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/aks_cfg_regs.sv =====
`default_nettype none

module aks_cfg_regs (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [aks_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [aks_pkg::LEVEL_BITS-1:0]      cfg_data,
	output aks_pkg::cfg_t                            cfg
);
	import aks_pkg::*;

	cfg_t cfg_q;

	// writes are always taken
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// register file, unknown indexes dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold <= RST_PRESS_THRESHOLD;
			cfg_q.level_limit[0]  <= RST_LEVEL0_LIMIT;
			cfg_q.level_limit[1]  <= RST_LEVEL1_LIMIT;
			cfg_q.level_limit[2]  <= RST_LEVEL2_LIMIT;
			cfg_q.level_limit[3]  <= RST_LEVEL3_LIMIT;
			cfg_q.level_limit[4]  <= RST_LEVEL4_LIMIT;
			cfg_q.level_limit[5]  <= RST_LEVEL5_LIMIT;
			cfg_q.level_limit[6]  <= RST_LEVEL6_LIMIT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_PRESS_THRESHOLD: cfg_q.press_threshold <= cfg_data;
				REG_LEVEL0_LIMIT:    cfg_q.level_limit[0]  <= cfg_data;
				REG_LEVEL1_LIMIT:    cfg_q.level_limit[1]  <= cfg_data;
				REG_LEVEL2_LIMIT:    cfg_q.level_limit[2]  <= cfg_data;
				REG_LEVEL3_LIMIT:    cfg_q.level_limit[3]  <= cfg_data;
				REG_LEVEL4_LIMIT:    cfg_q.level_limit[4]  <= cfg_data;
				REG_LEVEL5_LIMIT:    cfg_q.level_limit[5]  <= cfg_data;
				REG_LEVEL6_LIMIT:    cfg_q.level_limit[6]  <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/aks_scan_fsm.sv =====
`default_nettype none

module aks_scan_fsm (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	input  wire logic [aks_pkg::S_TDATA_BITS-1:0]  s_tdata,
	input  wire aks_pkg::cfg_t                     cfg,
	input  wire logic                              q_room,
	output aks_pkg::key_push_t                     push
);
	import aks_pkg::*;

	logic        valid_s1;
	level_t      lvl_s1;
	logic        acc_s1;
	logic        pw_s1;

	scan_state_t state_q, state_d;
	level_t      held_q, held_d;
	level_t      hold_q, hold_d;

	logic        accept;
	logic        advance;
	logic        up;
	logic        same;
	level_t      hold_inc;
	logic [SLOT_BITS-1:0] slot;
	key_opt_t    sc, lc;
	key_opt_t    opt_a, opt_b;

	// input stage moves on once the queue can take two results
	assign advance  = valid_s1 && q_room;
	assign s_tready = !valid_s1 || q_room;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input register, level is the top bits of the sample
	always_ff @(posedge clk) begin
		if (accept) begin
			lvl_s1 <= s_tdata[ADC_BITS-1 -: LEVEL_BITS];
			acc_s1 <= s_tdata[ADC_BITS];
			pw_s1  <= s_tdata[ADC_BITS+1];
		end
	end

	// key decode of the latched level
	assign up       = lvl_s1 >= cfg.press_threshold;
	assign same     = lvl_s1 == held_q;
	assign hold_inc = hold_q + 8'd1;
	assign slot     = slot_of(held_q, cfg.level_limit);
	assign sc       = short_code(slot, pw_s1);
	assign lc       = long_code(slot);

	// scanner next state and results
	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		hold_d  = hold_q;
		opt_a   = '0;
		opt_b   = '0;
		if (acc_s1) begin
			case (state_q)
				ST_IDLE: begin
					if (!up) begin
						state_d = ST_PRESS1;
						hold_d  = '0;
						held_d  = lvl_s1;
					end
				end
				ST_PRESS1: begin
					state_d = same ? ST_PRESS2 : ST_IDLE;
				end
				ST_PRESS2: begin
					if (same) begin
						state_d = ST_LONG;
						hold_d  = '0;
					end else begin
						state_d = ST_IDLE;
					end
				end
				ST_LONG: begin
					hold_d = hold_inc;
					if (hold_inc > LEVEL_BITS'(LONG_PRESS_TICKS)) begin
						opt_a   = lc;
						state_d = ST_RELEASE;
					end
					if (up) begin
						opt_b   = sc;
						state_d = ST_RELEASE;
					end
				end
				ST_RELEASE: begin
					if (up) begin
						state_d = ST_IDLE;
						if (hold_q > LEVEL_BITS'(LONG_PRESS_TICKS)) begin
							hold_d     = '0;
							opt_b.vld  = 1'b1;
							opt_b.code = KC_LONGEND;
						end
					end
				end
				default: begin
					state_d = ST_IDLE;
				end
			endcase
		end
	end

	// pack results, first valid one leads
	always_comb begin
		push.num    = advance ? ({1'b0, opt_a.vld} + {1'b0, opt_b.vld}) : 2'd0;
		push.code_a = opt_a.vld ? opt_a.code : opt_b.code;
		push.code_b = opt_b.code;
	end

	// scanner state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			hold_q  <= '0;
		end else if (advance) begin
			state_q <= state_d;
			held_q  <= held_d;
			hold_q  <= hold_d;
		end
	end

`ifndef SYNTHESIS
	a_hold_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		hold_q <= LEVEL_BITS'(LONG_PRESS_TICKS + 1))
		else $error("hold counter ran past the long press limit");

	a_pair_no_longend: assert property (@(posedge clk) disable iff (!arst_n)
		push.num == 2'd2 |-> (push.code_b != KC_LONGEND && state_q == ST_LONG))
		else $error("two results from a tick outside the long state");

	a_state_holds: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(state_q) && $stable(hold_q) && $stable(held_q)))
		else $error("scanner state moved without an item");
`endif

endmodule

`default_nettype wire

// ===== hdl/aks_out_queue.sv =====
`default_nettype none

module aks_out_queue (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire aks_pkg::key_push_t                push,
	output logic                                   q_room,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic [aks_pkg::M_TDATA_BITS-1:0]       m_tdata,
	output logic                                   m_tlast
);
	import aks_pkg::*;

	key_t                     code_mem [OUTQ_DEPTH];
	logic                     last_mem [OUTQ_DEPTH];
	logic [OUTQ_PTR_BITS-1:0] wp_q, rp_q, wp_nx;
	logic [OUTQ_CNT_BITS-1:0] cnt_q;
	logic                     pop;

	assign pop      = m_tvalid && m_tready;
	assign wp_nx    = wp_q + 1'b1;
	assign q_room   = cnt_q <= OUTQ_CNT_BITS'(OUTQ_DEPTH - 2);
	assign m_tvalid = cnt_q != '0;
	assign m_tdata  = {{(M_TDATA_BITS - KEY_BITS){1'b0}}, code_mem[rp_q]};
	assign m_tlast  = last_mem[rp_q];

	// result storage, up to two entries written per beat
	always_ff @(posedge clk) begin
		if (push.num != 2'd0) begin
			code_mem[wp_q] <= push.code_a;
			last_mem[wp_q] <= push.num == 2'd1;
		end
		if (push.num == 2'd2) begin
			code_mem[wp_nx] <= push.code_b;
			last_mem[wp_nx] <= 1'b1;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + OUTQ_PTR_BITS'(push.num);
			rp_q  <= rp_q + OUTQ_PTR_BITS'(pop);
			cnt_q <= cnt_q + OUTQ_CNT_BITS'(push.num) - OUTQ_CNT_BITS'(pop);
		end
	end

`ifndef SYNTHESIS
	a_cnt_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= OUTQ_CNT_BITS'(OUTQ_DEPTH))
		else $error("result queue overfilled");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.num != 2'd0 |-> q_room)
		else $error("results written without room");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && push.num == 2'd0) |=> cnt_q == $past(cnt_q) - 1'b1)
		else $error("fill count off after a beat left");
`endif

endmodule

`default_nettype wire

// ===== hdl/adc_ladder_key_scanner.sv =====
`default_nettype none

// Resistor-ladder keypad scanner. Each input beat is one 10 ms tick: the top eight bits of
// the ADC sample form the level, a level below press_threshold starts a press, two more
// equal levels confirm it, a hold longer than 120 ticks gives the long code, release gives
// the short code or, after a long press, a long-end marker. A tick gives zero, one or two
// result beats, the final one of the tick flagged by m_tlast. One input beat is accepted
// every cycle unless the input register is held; a beat waits there until its results are
// written to the queue, which raises m_tvalid. Results drain one beat a cycle while m_tready
// is high, through a four-entry queue, and the input register holds while that queue has
// fewer than two free entries, so a run of two-result ticks is paced by the drain.
// Configuration writes are taken at once and belong to idle periods.
module adc_ladder_key_scanner (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              s_tvalid,
	output logic                                   s_tready,
	// adc_sample, accessory_on, power_wait
	input  wire logic [aks_pkg::S_TDATA_BITS-1:0]  s_tdata,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	// key_code
	output logic [aks_pkg::M_TDATA_BITS-1:0]       m_tdata,
	output logic                                   m_tlast,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [aks_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [aks_pkg::LEVEL_BITS-1:0]    cfg_data
);
	import aks_pkg::*;

	cfg_t      cfg;
	key_push_t push;
	logic      q_room;

	// configuration registers
	aks_cfg_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// debounce and key decode
	aks_scan_fsm u_fsm (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.cfg      (cfg),
		.q_room   (q_room),
		.push     (push)
	);

	// result queue
	aks_out_queue u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.q_room   (q_room),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire
